@@ sv/crcfhc_pkg.sv @@
package crcfhc_pkg;

	// header layout
	localparam int HEADER_BYTES = 28;
	localparam int CRC_SPAN     = HEADER_BYTES - 4;
	localparam logic [4:0] POS_CRC_END = 5'(CRC_SPAN);
	localparam logic [4:0] POS_LAST    = 5'(HEADER_BYTES - 1);

	// CRC-32C, reflected
	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// header status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE    = 3'd3;
	localparam logic [2:0] ST_TOO_LONG    = 3'd4;

	// register map (word index)
	localparam int          REG_ADDR_W   = 5;
	localparam logic [2:0]  REG_MAGIC    = 3'd0;
	localparam logic [2:0]  REG_VERSION  = 3'd1;
	localparam logic [2:0]  REG_TYPE_LO  = 3'd2;
	localparam logic [2:0]  REG_TYPE_HI  = 3'd3;
	localparam logic [2:0]  REG_LIMIT    = 3'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       abort;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [15:0] frame_type;
		logic [31:0] frame_flags;
		logic [31:0] payload_length;
		logic [63:0] correlation_id;
		logic [7:0]  payload_byte;
		logic        crc_ok;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [15:0] expected_version;
		logic [15:0] type_lowest;
		logic [15:0] type_highest;
		logic [31:0] payload_limit;
	} cfg_t;

	// what one accepted byte produced
	typedef enum logic [1:0] {
		EV_HDR,
		EV_HDR_END,
		EV_PAY,
		EV_PAY_END
	} ev_t;

	typedef struct packed {
		ev_t         ev;
		logic [2:0]  status;
		logic        crc_ok;
		logic [7:0]  pbyte;
		logic [15:0] frame_type;
		logic [31:0] frame_flags;
		logic [31:0] payload_length;
		logic [63:0] correlation_id;
	} entry_t;

	// one byte through the CRC-32C register
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ sv/crc32c_frame_header_checker.sv @@
// Frame header checker with CRC-32C.
// Input side is a queue: drive item (rx_byte, abort) with push; the byte is
// taken on a clock edge where push is high and full is low. One byte per cycle.
// Result side is a queue: while empty is low the oldest result is on result;
// pulse pop to take it. A byte gives zero, one or two results: none for inner
// header bytes, a header verdict on the 28th byte, one payload result per
// payload byte, plus a frame end verdict after the last payload byte (or right
// after an ok header with zero length). last marks a byte's final result.
// A byte's entry is registered in the queue, behind any older entries.
// Throughput: one byte per cycle; the byte path (CRC update, header capture,
// checks) has no wait state. Results drain one per pop, so a byte with two
// results uses two pops. An entry queue of QUEUE_DEPTH bytes sits between the
// byte path and the result expander; when it fills because pop stays low, full
// rises and input stalls with no loss. abort drops the current frame and
// restarts header collection with that byte.
// Reset clears the queue, header position and counters and loads the
// register defaults; no clearing pass is needed. Registers are written over the
// APB port; the user must do this only while no bytes are in flight (unchecked).
module crc32c_frame_header_checker
	import crcfhc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t   cfg;
	logic   q_full, q_empty, q_wr, q_rd;
	entry_t q_wdata, q_rdata;

	crcfhc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crcfhc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.push    (push),
		.item    (item),
		.q_full  (q_full),
		.full    (full),
		.wr_en   (q_wr),
		.wr_data (q_wdata)
	);

	crcfhc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	crcfhc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

@@ sv/crcfhc_regs.sv @@
module crcfhc_regs
	import crcfhc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word       <= 32'd0;
			cfg_q.expected_version <= 16'd1;
			cfg_q.type_lowest      <= 16'd1;
			cfg_q.type_highest     <= 16'd8;
			cfg_q.payload_limit    <= 32'd1048576;
		end else if (wr) begin
			unique case (idx)
				REG_MAGIC:   cfg_q.magic_word       <= pwdata;
				REG_VERSION: cfg_q.expected_version <= pwdata[15:0];
				REG_TYPE_LO: cfg_q.type_lowest      <= pwdata[15:0];
				REG_TYPE_HI: cfg_q.type_highest     <= pwdata[15:0];
				REG_LIMIT:   cfg_q.payload_limit    <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_MAGIC:   prdata = cfg_q.magic_word;
			REG_VERSION: prdata = {16'd0, cfg_q.expected_version};
			REG_TYPE_LO: prdata = {16'd0, cfg_q.type_lowest};
			REG_TYPE_HI: prdata = {16'd0, cfg_q.type_highest};
			REG_LIMIT:   prdata = cfg_q.payload_limit;
			default:     prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/crcfhc_front.sv @@
module crcfhc_front
	import crcfhc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   push,
	input  item_t  item,
	input  logic   q_full,
	output logic   full,
	output logic   wr_en,
	output entry_t wr_data
);

	logic [4:0]  pos_q;
	logic        in_pay_q;
	logic [63:0] shift0_q, shift1_q, shift2_q;
	logic [31:0] rx_crc_q;
	logic [31:0] crc_q;
	logic [31:0] remain_q;

	logic        accept;
	logic        eff_pay;
	logic [4:0]  eff_pos;
	logic [31:0] eff_crc;
	logic [31:0] crc_next;
	logic [31:0] rx_crc_next;
	logic        hdr_done;
	logic        pay_end;
	logic [2:0]  status;
	logic [31:0] length;
	logic [15:0] ftype;

	assign full   = q_full;
	assign accept = push & ~q_full;

	// abort restarts the frame before this byte is looked at
	assign eff_pay = in_pay_q & ~item.abort;
	assign eff_pos = item.abort ? 5'd0 : pos_q;
	assign eff_crc = item.abort ? CRC_INIT : crc_q;

	assign crc_next    = crc_byte(eff_crc, item.rx_byte);
	assign rx_crc_next = {rx_crc_q[23:0], item.rx_byte};
	assign hdr_done    = ~eff_pay & (eff_pos == POS_LAST);
	assign pay_end     = remain_q == 32'd1;
	assign length      = shift1_q[31:0];
	assign ftype       = shift0_q[15:0];

	// header checks, first failure wins
	always_comb begin
		priority if (shift0_q[63:32] != cfg.magic_word)
			status = ST_BAD_MAGIC;
		else if (shift0_q[31:16] != cfg.expected_version)
			status = ST_BAD_VERSION;
		else if (ftype < cfg.type_lowest || ftype > cfg.type_highest)
			status = ST_BAD_TYPE;
		else if (length > cfg.payload_limit)
			status = ST_TOO_LONG;
		else
			status = ST_OK;
	end

	// queue entry for this byte
	always_comb begin
		wr_en                  = accept & (eff_pay | hdr_done);
		wr_data.status         = ST_OK;
		wr_data.pbyte          = item.rx_byte;
		wr_data.frame_type     = ftype;
		wr_data.frame_flags    = shift1_q[63:32];
		wr_data.payload_length = length;
		wr_data.correlation_id = shift2_q;
		if (eff_pay) begin
			wr_data.ev     = pay_end ? EV_PAY_END : EV_PAY;
			wr_data.crc_ok = (crc_next ^ CRC_INIT) == rx_crc_q;
		end else begin
			wr_data.status = status;
			wr_data.ev     = (status == ST_OK && length == 32'd0) ? EV_HDR_END : EV_HDR;
			wr_data.crc_ok = (eff_crc ^ CRC_INIT) == rx_crc_next;
		end
	end

	// header capture, running CRC, payload count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 5'd0;
			in_pay_q <= 1'b0;
			shift0_q <= 64'd0;
			shift1_q <= 64'd0;
			shift2_q <= 64'd0;
			rx_crc_q <= 32'd0;
			crc_q    <= CRC_INIT;
			remain_q <= 32'd0;
		end else if (accept) begin
			if (eff_pay) begin
				if (pay_end) begin
					in_pay_q <= 1'b0;
					pos_q    <= 5'd0;
					crc_q    <= CRC_INIT;
					remain_q <= 32'd0;
				end else begin
					crc_q    <= crc_next;
					remain_q <= remain_q - 32'd1;
				end
			end else begin
				if (eff_pos < POS_CRC_END) begin
					unique case (eff_pos[4:3])
						2'd0:    shift0_q <= {shift0_q[55:0], item.rx_byte};
						2'd1:    shift1_q <= {shift1_q[55:0], item.rx_byte};
						default: shift2_q <= {shift2_q[55:0], item.rx_byte};
					endcase
				end else begin
					rx_crc_q <= rx_crc_next;
				end
				if (hdr_done) begin
					pos_q <= 5'd0;
					if (status == ST_OK && length != 32'd0) begin
						in_pay_q <= 1'b1;
						remain_q <= length;
						crc_q    <= eff_crc;
					end else begin
						in_pay_q <= 1'b0;
						remain_q <= 32'd0;
						crc_q    <= CRC_INIT;
					end
				end else begin
					in_pay_q <= 1'b0;
					remain_q <= 32'd0;
					pos_q    <= eff_pos + 5'd1;
					// checksum bytes stay out of the CRC
					crc_q    <= (eff_pos < POS_CRC_END) ? crc_next : eff_crc;
				end
			end
		end
	end

endmodule

@@ sv/crcfhc_queue.sv @@
module crcfhc_queue
	import crcfhc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	output logic   full,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/crcfhc_back.sv @@
module crcfhc_back
	import crcfhc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  head,
	input  logic    q_empty,
	output logic    q_rd,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	logic sub_q;
	logic two;
	logic take;
	logic is_end;

	assign two    = head.ev == EV_HDR_END || head.ev == EV_PAY_END;
	assign empty  = q_empty;
	assign take   = pop & ~q_empty;
	assign q_rd   = take & (~two | sub_q);
	assign is_end = two & sub_q;

	// expand one entry into its results
	always_comb begin
		result.frame_type     = head.frame_type;
		result.frame_flags    = head.frame_flags;
		result.payload_length = head.payload_length;
		result.correlation_id = head.correlation_id;
		result.status         = ST_OK;
		result.payload_byte   = 8'd0;
		result.crc_ok         = 1'b0;
		result.last           = ~two | sub_q;
		if (is_end) begin
			result.kind   = KIND_END;
			result.crc_ok = head.crc_ok;
		end else if (head.ev == EV_PAY || head.ev == EV_PAY_END) begin
			result.kind         = KIND_PAYLOAD;
			result.payload_byte = head.pbyte;
		end else begin
			result.kind   = KIND_HEADER;
			result.status = head.status;
		end
	end

	// second-result select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (take) begin
			sub_q <= two & ~sub_q;
		end
	end

endmodule

@@ tb/crc32c_frame_header_checker_tb.sv @@
`timescale 1ns / 1ps

module crc32c_frame_header_checker_tb;
	import crcfhc_pkg::*;

	// Expected-result tracker: mirrors the deframer state and config
	class frame_scoreboard;
		cfg_t             cfg;
		logic [4:0]       hdr_pos;
		bit               in_payload;
		logic [2:0][63:0] hdr_word;
		logic [31:0]      rx_sum;
		logic [31:0]      crc;
		logic [31:0]      remaining;
		result_t          pending_results[$];
		int               mismatches;

		function new();
			cfg.magic_word       = 32'd0;
			cfg.expected_version = 16'd1;
			cfg.type_lowest      = 16'd1;
			cfg.type_highest     = 16'd8;
			cfg.payload_limit    = 32'd1048576;
			hdr_word   = '0;
			rx_sum     = '0;
			mismatches = 0;
			restart();
		endfunction

		// reflected CRC-32C, one data bit per step, LSB first
		function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int i = 0; i < 8; i++) begin
				fb = r[0] ^ b[i];
				r  = r >> 1;
				if (fb)
					r = r ^ CRC_POLY;
			end
			return r;
		endfunction

		function void restart();
			hdr_pos    = '0;
			in_payload = 1'b0;
			crc        = CRC_INIT;
			remaining  = '0;
		endfunction

		// fields of the last collected header ride along in every result
		function result_t make_result(logic [1:0] kind, logic [2:0] status,
			logic [7:0] pbyte, logic ok);
			result_t r;
			r.kind           = kind;
			r.status         = status;
			r.frame_type     = hdr_word[0][15:0];
			r.frame_flags    = hdr_word[1][63:32];
			r.payload_length = hdr_word[1][31:0];
			r.correlation_id = hdr_word[2];
			r.payload_byte   = pbyte;
			r.crc_ok         = ok;
			r.last           = 1'b0;
			return r;
		endfunction

		function result_t end_verdict();
			result_t r;
			r = make_result(KIND_END, ST_OK, 8'd0, (crc ^ 32'hFFFF_FFFF) == rx_sum);
			restart();
			return r;
		endfunction

		function void take_byte(item_t it);
			result_t     res[2];
			int          n;
			logic [1:0]  w;
			logic [2:0]  st;
			logic [15:0] ty;
			logic [31:0] len;
			n = 0;
			if (it.abort)
				restart();
			if (in_payload) begin
				crc = crc_step(crc, it.rx_byte);
				res[n] = make_result(KIND_PAYLOAD, ST_OK, it.rx_byte, 1'b0);
				n++;
				remaining = remaining - 32'd1;
				if (remaining == 32'd0) begin
					res[n] = end_verdict();
					n++;
				end
			end else begin
				// header capture; checksum bytes stay out of the CRC
				if (hdr_pos < POS_CRC_END) begin
					w = hdr_pos[4:3];
					hdr_word[w] = {hdr_word[w][55:0], it.rx_byte};
					crc = crc_step(crc, it.rx_byte);
				end else begin
					rx_sum = {rx_sum[23:0], it.rx_byte};
				end
				if (hdr_pos >= POS_LAST) begin
					ty  = hdr_word[0][15:0];
					len = hdr_word[1][31:0];
					if (hdr_word[0][63:32] != cfg.magic_word)
						st = ST_BAD_MAGIC;
					else if (hdr_word[0][31:16] != cfg.expected_version)
						st = ST_BAD_VERSION;
					else if (ty < cfg.type_lowest || ty > cfg.type_highest)
						st = ST_BAD_TYPE;
					else if (len > cfg.payload_limit)
						st = ST_TOO_LONG;
					else
						st = ST_OK;
					res[n] = make_result(KIND_HEADER, st, 8'd0, 1'b0);
					n++;
					if (st != ST_OK) begin
						restart();
					end else if (len == 32'd0) begin
						res[n] = end_verdict();
						n++;
					end else begin
						hdr_pos    = '0;
						in_payload = 1'b1;
						remaining  = len;
					end
				end else begin
					hdr_pos = hdr_pos + 5'd1;
				end
			end
			if (n > 0)
				res[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++)
				pending_results = {pending_results, res[i]};
		endfunction

		function string describe(result_t r);
			return {$sformatf("kind %0d status %0d type %h flags %h len %h ",
				r.kind, r.status, r.frame_type, r.frame_flags, r.payload_length),
				$sformatf("corr %h byte %h crc_ok %b last %b",
				r.correlation_id, r.payload_byte, r.crc_ok, r.last)};
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %s", $time, describe(got));
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push;
	logic                  full;
	item_t                 item;
	logic                  empty;
	logic                  pop;
	result_t               result;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	frame_scoreboard sb;
	int              bytes_sent;
	int              burst_left;
	bit              offering;
	bit              pending_abort;
	bit              hold_request;

	crc32c_frame_header_checker i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// one byte request; bursts end in a random gap
	task automatic send_byte(input logic [7:0] b, input logic ab);
		item_t it;
		it.rx_byte = b;
		it.abort   = ab;
		push     <= 1'b1;
		item     <= it;
		offering = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.take_byte(it);
		bytes_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			push     <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(100, 300);
			else
				burst_left = $urandom_range(1, 24);
		end
	endtask

	// header (24 bytes + checksum) then payload; cut >= 0 sends only that many bytes
	task automatic send_frame(input logic [31:0] mg, input logic [15:0] ver,
		input logic [15:0] ty, input logic [31:0] fl, input logic [31:0] len,
		input logic [63:0] corr, input int pay_n, input int cut, input bit bad_crc,
		input bit ab);
		logic [191:0] h;
		logic [7:0]   fb[$];
		logic [7:0]   pb[$];
		logic [31:0]  c;
		int           n;
		h = {mg, ver, ty, fl, len, corr};
		c = CRC_INIT;
		for (int i = 0; i < 24; i++) begin
			fb = {fb, h[191 - 8 * i -: 8]};
			c = sb.crc_step(c, h[191 - 8 * i -: 8]);
		end
		for (int i = 0; i < pay_n; i++) begin
			pb = {pb, 8'($urandom)};
			c = sb.crc_step(c, pb[i]);
		end
		c = c ^ 32'hFFFF_FFFF;
		if (bad_crc)
			c = c ^ (32'h1 << $urandom_range(0, 31));
		for (int i = 3; i >= 0; i--)
			fb = {fb, c[8 * i +: 8]};
		n = (cut >= 0) ? cut : HEADER_BYTES + pay_n;
		for (int i = 0; i < n; i++)
			send_byte((i < HEADER_BYTES) ? fb[i] : pb[i - HEADER_BYTES], (i == 0) ? ab : 1'b0);
	endtask

	// one random frame: mostly well-formed, some failing, cut short or noise
	task automatic random_frame();
		int          pick;
		int          e;
		logic [31:0] mg;
		logic [31:0] fl;
		logic [31:0] len;
		logic [31:0] lim;
		logic [15:0] ver;
		logic [15:0] ty;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [63:0] corr;
		int          pay;
		bit          ab;
		bit          range_ok;
		pick     = $urandom_range(0, 99);
		mg       = sb.cfg.magic_word;
		ver      = sb.cfg.expected_version;
		lo       = sb.cfg.type_lowest;
		hi       = sb.cfg.type_highest;
		lim      = sb.cfg.payload_limit;
		range_ok = (lo <= hi);
		fl       = $urandom;
		corr     = {$urandom, $urandom};
		len      = $urandom_range(0, (lim < 16) ? lim : 16);
		if (!range_ok)
			ty = 16'($urandom);
		else begin
			case ($urandom_range(0, 3))
				0:       ty = lo;
				1:       ty = hi;
				default: ty = 16'($urandom_range(hi, lo));
			endcase
		end
		ab = pending_abort || ($urandom_range(0, 9) == 0);
		pending_abort = 1'b0;
		if (pick < 55) begin
			send_frame(mg, ver, ty, fl, len, corr, range_ok ? int'(len) : 0, -1,
				$urandom_range(0, 7) == 0, ab);
		end else if (pick < 72) begin
			// failing header; fall back when a check cannot fail under this setting
			e = $urandom_range(0, 3);
			if (e == 2 && range_ok && lo == 16'h0000 && hi == 16'hFFFF)
				e = 0;
			if (e == 3 && lim == 32'hFFFF_FFFF)
				e = 1;
			case (e)
				0: mg = mg ^ (($urandom % 32'hFFFF_FFFF) + 32'd1);
				1: ver = ver ^ 16'(($urandom % 32'hFFFF) + 32'd1);
				2: begin
					if (range_ok) begin
						if (lo != 16'h0000 && (hi == 16'hFFFF || $urandom_range(0, 1) == 1))
							ty = 16'($urandom_range(lo - 1, 0));
						else
							ty = 16'($urandom_range(16'hFFFF, hi + 1));
					end
				end
				default: len = $urandom_range(32'hFFFF_FFFF, lim + 32'd1);
			endcase
			send_frame(mg, ver, ty, fl, len, corr, 0, -1, 1'b0, ab);
		end else if (pick < 80) begin
			// large declared length, payload cut short
			if (lim == 32'd0)
				len = 32'd0;
			else if (lim == 32'hFFFF_FFFF)
				len = $urandom;
			else
				len = $urandom_range(lim, 1);
			if (len == 32'd0 || !range_ok)
				pay = 0;
			else
				pay = $urandom_range(0, (len > 6) ? 6 : len - 1);
			send_frame(mg, ver, ty, fl, len, corr, pay, -1, 1'b0, ab);
			pending_abort = (len != 32'd0) && range_ok;
		end else if (pick < 88) begin
			// header cut short
			send_frame(mg, ver, ty, fl, len, corr, 0, $urandom_range(1, HEADER_BYTES - 1),
				1'b0, ab);
			pending_abort = 1'b1;
		end else if (pick < 94) begin
			// line noise
			repeat ($urandom_range(1, 12))
				send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			pending_abort = 1'b1;
		end else begin
			send_frame(mg, ver, ty, fl, len, corr, range_ok ? int'(len) : 0, -1, 1'b0, 1'b1);
		end
	endtask

	task automatic run_random(input int n, input bit squeeze);
		int stop_at;
		bit squeezed;
		stop_at  = bytes_sent + n;
		squeezed = 1'b0;
		while (bytes_sent < stop_at) begin
			if (squeeze && !squeezed && bytes_sent >= stop_at - n / 2) begin
				hold_request = 1'b1;
				squeezed     = 1'b1;
			end
			random_frame();
		end
	endtask

	task automatic wait_drained();
		if (offering) begin
			push     <= 1'b0;
			offering = 1'b0;
		end
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		// bytes without results may still be in the pipe
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input cfg_t c);
		wait_drained();
		write_reg(REG_MAGIC, c.magic_word);
		write_reg(REG_VERSION, {16'd0, c.expected_version});
		write_reg(REG_TYPE_LO, {16'd0, c.type_lowest});
		write_reg(REG_TYPE_HI, {16'd0, c.type_highest});
		write_reg(REG_LIMIT, c.payload_limit);
		sb.cfg = c;
	endtask

	function automatic cfg_t random_setting();
		cfg_t        c;
		logic [15:0] a;
		logic [15:0] b;
		c.magic_word       = $urandom;
		c.expected_version = 16'($urandom);
		a = 16'($urandom);
		b = 16'($urandom);
		c.type_lowest  = (a <= b) ? a : b;
		c.type_highest = (a <= b) ? b : a;
		case ($urandom_range(0, 2))
			0:       c.payload_limit = $urandom_range(0, 40);
			1:       c.payload_limit = $urandom;
			default: c.payload_limit = 32'hFFFF_FFFF;
		endcase
		return c;
	endfunction

	// receiver: random pop pattern in modes, plus long hold-offs
	initial begin
		int hold_left;
		int mode_left;
		int pop_pct;
		int seen;
		hold_left = 0;
		mode_left = 0;
		pop_pct   = 100;
		seen      = 0;
		pop       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(result);
				seen++;
				if (seen % 600 == 0)
					hold_left = 200;
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = 300;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(16, 128);
				case ($urandom_range(0, 3))
					0:       pop_pct = 100;
					1:       pop_pct = 70;
					2:       pop_pct = 40;
					default: pop_pct = 10;
				endcase
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(1, 100) <= pop_pct);
			end
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("crc32c_frame_header_checker verification failed");
		$finish;
	end

	initial begin
		cfg_t c;
		sb            = new();
		push          = 1'b0;
		item          = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		bytes_sent    = 0;
		burst_left    = $urandom_range(1, 24);
		offering      = 1'b0;
		pending_abort = 1'b0;
		hold_request  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under reset settings
		send_frame(32'h0, 16'h1, 16'h1, 32'h0, 32'h0, 64'h0, 0, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'h8, 32'hFFFF_FFFF, 32'd3, '1, 3, -1, 1'b0, 1'b1);
		send_frame(32'h0, 16'h1, 16'h5, $urandom, 32'd2, {$urandom, $urandom}, 2, -1,
			1'b1, 1'b0);
		send_frame(32'hFFFF_FFFF, 16'h1, 16'h1, $urandom, 32'd0, 64'h0, 0, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'hFFFF, 16'h1, $urandom, 32'd0, 64'h0, 0, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'h0, $urandom, 32'd0, 64'h0, 0, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'hFFFF, $urandom, 32'd0, 64'h0, 0, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'h3, $urandom, 32'hFFFF_FFFF, '1, 0, -1, 1'b0, 1'b0);
		// length right at the limit, payload dropped by an abort
		send_frame(32'h0, 16'h1, 16'h3, $urandom, 32'd1048576, 64'h0, 4, -1, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'h2, $urandom, 32'd1, {$urandom, $urandom}, 1, -1,
			1'b0, 1'b1);
		// header dropped by an abort
		send_frame(32'h0, 16'h1, 16'h6, $urandom, 32'd5, 64'h0, 0, 13, 1'b0, 1'b0);
		send_frame(32'h0, 16'h1, 16'h7, $urandom, 32'd1, 64'h0, 1, -1, 1'b0, 1'b1);

		run_random(250, 1'b0);

		apply_setting(random_setting());
		run_random(250, 1'b1);

		// widest setting
		c = {32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF};
		apply_setting(c);
		run_random(250, 1'b0);

		// narrowest setting: type 0 and zero length only
		c = '0;
		apply_setting(c);
		run_random(250, 1'b0);

		// empty type range
		c = random_setting();
		c.type_lowest  = 16'($urandom_range(16'hFFFF, 1));
		c.type_highest = 16'($urandom_range(c.type_lowest - 1, 0));
		apply_setting(c);
		run_random(250, 1'b1);

		apply_setting(random_setting());
		run_random(250, 1'b0);

		wait_drained();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("crc32c_frame_header_checker verification clean");
		else
			$display("crc32c_frame_header_checker verification failed");
		$finish;
	end

endmodule

@@ crc32c_frame_header_checker.f @@
sv/crcfhc_pkg.sv
sv/crcfhc_regs.sv
sv/crcfhc_front.sv
sv/crcfhc_queue.sv
sv/crcfhc_back.sv
sv/crc32c_frame_header_checker.sv
tb/crc32c_frame_header_checker_tb.sv
